// ===== rtl/dag_pkg.sv =====
// Shared types and constants of the deduplicating acknowledgement queue.
`default_nettype none

package dag_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned FILL_W          = 5;
	localparam int unsigned ACK_W           = 32;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_DUP  = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} dag_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/dag_ctrl.sv =====
// Controller state machine of the deduplicating acknowledgement queue.
`default_nettype none

module dag_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output dag_pkg::dag_ctrl_t ctrl
);
	import dag_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	// The result register may be loaded when empty or when its word leaves now.
	assign slot_free = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctrl.load = 1'b0;
		ctrl.exec = 1'b0;
		state_d   = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					ctrl.exec = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= ctrl.exec || (out_valid_q && out_stall);
		end
	end

`ifndef SYNTHESIS
	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> state_q == S_EXEC)
		else $error("load did not lead to the execute state");

	a_exec_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.exec |=> out_valid_q)
		else $error("executed command left no result word");

	a_wait_for_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && out_valid_q && out_stall |=> state_q == S_EXEC)
		else $error("command executed over a held result word");
`endif

endmodule

`default_nettype wire

// ===== rtl/dag_datapath.sv =====
// Datapath of the deduplicating acknowledgement queue: cells, compare and shift.
`default_nettype none

module dag_datapath #(
	parameter int unsigned Depth = dag_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dag_pkg::dag_ctrl_t          ctrl,
	input  logic [1:0]                  command,
	input  logic [dag_pkg::ACK_W-1:0]   ack_value,
	output logic                        success,
	output logic [dag_pkg::ACK_W-1:0]   value_out,
	output logic [1:0]                  status,
	output logic [dag_pkg::FILL_W-1:0]  fill_level
);
	import dag_pkg::*;

	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam int unsigned IdxW = $clog2(Depth);

	cmd_t                cmd_s1;
	logic [ACK_W-1:0]    val_s1;
	logic [ACK_W-1:0]    entry_q [Depth];
	logic [ACK_W-1:0]    shift_src [Depth];
	logic [CntW-1:0]     count_q;
	logic [CntW-1:0]     count_d;
	logic [Depth-1:0]    match;
	logic [IdxW-1:0]     match_idx;
	logic [IdxW-1:0]     del_pos;
	logic                found;
	logic                full;
	logic                empty;
	logic                push_ok;
	logic                del_ok;
	logic                res_ok;
	logic [ACK_W-1:0]    res_val;
	status_t             res_st;
	logic                success_q;
	logic [ACK_W-1:0]    value_q;
	status_t             status_q;
	logic [FILL_W-1:0]   fill_q;

	// Each cell compares its entry with the operand; only held entries take part.
	always_comb begin
		for (int i = 0; i < Depth; i++) begin
			match[i] = (CntW'(i) < count_q) && (entry_q[i] == val_s1);
		end
	end

	// Numbers are held once at most, so the match vector is one-hot or empty.
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < Depth; i++) begin
			if (match[i]) begin
				match_idx = match_idx | IdxW'(i);
			end
		end
	end

	assign found = |match;
	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);

	always_comb begin
		push_ok = 1'b0;
		del_ok  = 1'b0;
		del_pos = match_idx;
		res_ok  = 1'b0;
		res_val = '0;
		res_st  = ST_DONE;
		count_d = count_q;
		case (cmd_s1)
			CMD_PUSH: begin
				if (found) begin
					res_st = ST_DUP;
				end else if (full) begin
					res_st = ST_FULL;
				end else begin
					push_ok = 1'b1;
					res_ok  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP: begin
				if (empty) begin
					res_st = ST_MISS;
				end else begin
					del_ok  = 1'b1;
					del_pos = '0;
					res_ok  = 1'b1;
					res_val = entry_q[0];
					count_d = count_q - 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (!found) begin
					res_st = ST_MISS;
				end else begin
					del_ok  = 1'b1;
					res_ok  = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			CMD_QUERY: begin
				if (found) begin
					res_ok = 1'b1;
				end else begin
					res_st = ST_MISS;
				end
			end
			default: begin
				res_st = ST_MISS;
			end
		endcase
	end

	// Each cell takes its neighbour's entry on a shift; the last keeps its own.
	for (genvar g = 0; g < Depth; g++) begin : g_src
		if (g < Depth - 1) begin : g_mid
			assign shift_src[g] = entry_q[g + 1];
		end else begin : g_last
			assign shift_src[g] = entry_q[g];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			for (int i = 0; i < Depth; i++) begin
				if (del_ok && (IdxW'(i) >= del_pos)) begin
					entry_q[i] <= shift_src[i];
				end else if (push_ok && (count_q == CntW'(i))) begin
					entry_q[i] <= val_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_s1 <= cmd_t'(command);
			val_s1 <= ack_value;
		end
		if (ctrl.exec) begin
			success_q <= res_ok;
			value_q   <= res_val;
			status_q  <= res_st;
			fill_q    <= FILL_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.exec) begin
			count_q <= count_d;
		end
	end

	assign success    = success_q;
	assign value_out  = value_q;
	assign status     = status_q;
	assign fill_level = fill_q;

`ifndef SYNTHESIS
	a_no_dup_held: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("a number is held in more than one cell");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("entry count beyond queue depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.exec && push_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("accepted push did not grow the queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/dedup_ack_queue.sv =====
// Top level of the deduplicating acknowledgement queue.
//
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  command, ack_value
// result    out        out_valid/ out_stall success, value_out, status, fill_level
//
// Each command is first captured and then executed in a step in which all
// cells compare against the operand in parallel and the queue pushes or shifts.
// A new command is not taken until the current one has executed.
// The result register parts the two sides: a command is taken while a result
// still waits, and it waits in its execute cycle only while that result is held.
// Reset clears the entry count and the handshake state; the cells hold no reset.
`default_nettype none

module dedup_ack_queue #(
	parameter int unsigned QUEUE_DEPTH = dag_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] ack_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        success,
	output logic [31:0] value_out,
	output logic [1:0]  status,
	output logic [4:0]  fill_level
);
	import dag_pkg::*;

	// Commands from the state machine to the cells and result register.
	dag_ctrl_t ctrl;

	// The controller sequences capture and execution and owns in_stall and out_valid.
	dag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	// The datapath holds the cells in arrival order, the oldest in the first,
	// along with the entry count and the registered result word.
	dag_datapath #(
		.Depth (QUEUE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.command    (command),
		.ack_value  (ack_value),
		.success    (success),
		.value_out  (value_out),
		.status     (status),
		.fill_level (fill_level)
	);

endmodule

`default_nettype wire
